FILE: design/dts_pkg.sv
// Shared types, constants and helpers for the share-target divider.
// No dependencies; every other file in this folder uses it.
package dts_pkg;

  localparam int unsigned NumW   = 256;              // quotient and numerator width
  localparam int unsigned WordW  = 64;               // divisor, remainder, output word
  localparam int unsigned NWords = NumW / WordW;
  localparam int unsigned IdxW   = $clog2(NWords);
  localparam int unsigned StepW  = $clog2(NumW);     // one division step per numerator bit
  localparam int unsigned NCells = 64;

  // Difficulty-one target: 0xFFFF0000 at bit 192, so bits 223..208 are set.
  localparam logic [31:0]      Diff1HiWord32 = 32'hFFFF0000;
  localparam logic [StepW-1:0] OnesLo        = StepW'(208);
  localparam logic [StepW-1:0] OnesHi        = StepW'(223);

  localparam logic [IdxW-1:0]  LastIdx = IdxW'(NWords - 1);

  // Word handed from one cell to the next.
  typedef struct packed {
    logic             valid;
    logic [StepW-1:0] step;   // division steps already done, wraps to zero when finished
    logic [WordW-1:0] dvs;    // divisor, never zero
    logic [WordW-1:0] rem;
    logic [NumW-1:0]  quo;    // quotient bits, shifted in from the bottom
  } cell_t;

  // Numerator bit consumed at a given step: bit position is NumW-1-step.
  function automatic logic num_bit(input logic [StepW-1:0] step);
    logic [StepW-1:0] pos;
    pos = ~step;
    return (pos >= OnesLo) && (pos <= OnesHi);
  endfunction

endpackage

FILE: design/dts_if.sv
// Valid/ready channel interfaces for difficulty input and target words.
// Depends on dts_pkg for field widths.
interface dts_in_if;
  logic                        valid;
  logic                        ready;
  logic [dts_pkg::WordW-1:0]   difficulty;

  modport source (output valid, output difficulty, input ready);
  modport sink   (input valid, input difficulty, output ready);
endinterface

interface dts_out_if;
  logic                        valid;
  logic                        ready;
  logic [dts_pkg::IdxW-1:0]    word_index;
  logic [dts_pkg::WordW-1:0]   target_word;
  logic                        last_word;

  modport source (output valid, output word_index, output target_word, output last_word,
                  input ready);
  modport sink   (input valid, input word_index, input target_word, input last_word,
                  output ready);
endinterface

FILE: design/difficulty_to_share_target.sv
// Share target from pool difficulty: target = (0xFFFF << 208) / difficulty, truncated,
// with a difficulty of zero taken as one. Each accepted difficulty word yields four
// target words on the output channel, least significant first, the fourth flagged
// last_word. The division runs on a ring of 64 identical cells, each doing one
// restoring step (a 64-bit shift, compare and subtract) per cycle unless the ring is
// held, and handing its word to the next cell. A difficulty goes round the ring four
// times, then its target is loaded into the output register and the first word can
// be taken on the following cycle. Each difficulty holds one of the 64 ring slots
// until then; the output side moves one word per cycle while the receiver is ready.
// Up to 64 difficulties are in flight at once. A new difficulty is taken whenever the
// slot arriving back at the first cell is empty or holds a finished target that the
// output register can take at once. If a finished target reaches the end of the ring
// while the output register is still full, the whole ring holds until it can be
// unloaded. Results leave in acceptance order.
// Depends on dts_pkg, dts_if, dts_cell and dts_ser.
module difficulty_to_share_target (
  input  logic     clk_i,
  input  logic     rst_ni,
  dts_in_if.sink   din_i,
  dts_out_if.source dout_o
);
  import dts_pkg::*;

  cell_t c_out [NCells];
  cell_t entry;
  cell_t tail;
  logic  recirc;
  logic  done;
  logic  can_load;
  logic  adv;
  logic  retire;
  logic  in_acc;

  assign tail   = c_out[NCells-1];
  // a word with a non-zero step count still has laps to go
  assign recirc = tail.valid && (tail.step != '0);
  assign done   = tail.valid && (tail.step == '0);

  // hold the ring only while a finished target cannot be unloaded
  assign adv    = !done || can_load;
  assign retire = done && can_load;

  assign din_i.ready = adv && !recirc;
  assign in_acc      = din_i.valid && din_i.ready;

  // Ring entry: a word coming round again has priority over a new difficulty.
  always_comb begin
    entry = tail;
    if (!recirc) begin
      entry.valid = in_acc;
      entry.step  = '0;
      entry.dvs   = (din_i.difficulty == '0) ? WordW'(1) : din_i.difficulty;
      entry.rem   = '0;
      entry.quo   = '0;
    end
  end

  for (genvar k = 0; k < NCells; k++) begin : g_cell
    if (k == 0) begin : g_first
      dts_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (adv),
        .cell_i (entry),
        .cell_o (c_out[k])
      );
    end else begin : g_rest
      dts_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (adv),
        .cell_i (c_out[k-1]),
        .cell_o (c_out[k])
      );
    end
  end

  dts_ser u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (retire),
    .quo_i      (tail.quo),
    .can_load_o (can_load),
    .out_o      (dout_o)
  );

`ifndef NO_ASSERTIONS
  // an accepted difficulty lands in the first cell with one step done
  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (c_out[0].valid && (c_out[0].step == StepW'(1))))
    else $error("accepted difficulty did not enter the ring");

  // a retired target starts on its least significant word
  a_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    retire |=> (dout_o.valid && (dout_o.word_index == '0)))
    else $error("retired target not presented from word zero");

  // words of one target advance one index per transfer
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dout_o.valid && dout_o.ready && !dout_o.last_word) |=>
      (dout_o.valid && (dout_o.word_index == $past(dout_o.word_index) + IdxW'(1))))
    else $error("target word sequence broken");

  // a held ring keeps its finished target at the end
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> (tail.valid && (tail.step == '0)))
    else $error("finished target lost while ring held");
`endif

endmodule

FILE: design/dts_cell.sv
// One restoring long-division step per cycle while enabled, registered.
// Depends on dts_pkg (cell_t, num_bit).
module dts_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  dts_pkg::cell_t cell_i,
  output dts_pkg::cell_t cell_o
);
  import dts_pkg::*;

  logic             carry;
  logic [WordW-1:0] rem_sh;
  logic [WordW+1:0] diff;
  logic             ge;
  cell_t            cell_d;
  logic             valid_q;
  cell_t            pay_q;

  // Shift in the next numerator bit; the bit shifted out counts as 2^64.
  assign carry  = cell_i.rem[WordW-1];
  assign rem_sh = {cell_i.rem[WordW-2:0], num_bit(cell_i.step)};
  assign diff   = {1'b0, carry, rem_sh} - {2'b00, cell_i.dvs};
  assign ge     = ~diff[WordW+1];

  always_comb begin
    cell_d       = cell_i;
    cell_d.step  = cell_i.step + StepW'(1);
    cell_d.rem   = ge ? diff[WordW-1:0] : rem_sh;
    cell_d.quo   = {cell_i.quo[NumW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= cell_d;
    end
  end

  always_comb begin
    cell_o       = pay_q;
    cell_o.valid = valid_q;
  end

endmodule

FILE: design/dts_ser.sv
// Splits a finished 256-bit target into four 64-bit words, least significant first.
// Depends on dts_pkg and dts_out_if.
module dts_ser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic [dts_pkg::NumW-1:0] quo_i,
  output logic                     can_load_o,
  dts_out_if.source                out_o
);
  import dts_pkg::*;

  logic            busy_q, busy_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic            xfer;
  logic            at_last;

  assign at_last    = (cnt_q == LastIdx);
  assign xfer       = busy_q && out_o.ready;
  assign can_load_o = !busy_q || (out_o.ready && at_last);

  assign out_o.valid       = busy_q;
  assign out_o.word_index  = cnt_q;
  assign out_o.target_word = quo_q[WordW-1:0];
  assign out_o.last_word   = at_last;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    if (load_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = quo_i;
    end else if (xfer) begin
      // drop the word just taken, advance to the next one
      busy_d = !at_last;
      cnt_d  = cnt_q + IdxW'(1);
      quo_d  = {{WordW{1'b0}}, quo_q[NumW-1:WordW]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

endmodule

FILE: tb/sv/difficulty_to_share_target_tb.sv
// Self-checking testbench for the share-target divider: drives difficulty words,
// predicts each 256-bit target and checks the four target words that come back.
// Depends on dts_pkg, dts_if and the difficulty_to_share_target RTL.
`timescale 1ns / 100ps

module difficulty_to_share_target_tb;
  import dts_pkg::*;

  localparam int unsigned RandomItems = 259;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned MaxPrinted  = 20;

  // One expected target word, as it should leave the output channel.
  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [WordW-1:0] word;
    logic             last;
  } target_word_t;

  logic clk_i;
  logic rst_ni;

  // Channel towards the block and channel back from it.
  dts_in_if  din ();
  dts_out_if dout ();

  difficulty_to_share_target u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .din_i  (din),
    .dout_o (dout)
  );

  // Scoreboard: holds the target words still owed by the block, oldest first.
  class share_target_board;
    target_word_t words_due[$];
    int unsigned  errors;
    int unsigned  words_seen;
    int unsigned  difficulties_seen;

    // Truncating quotient of the difficulty-one target; zero divides as one.
    function automatic logic [NumW-1:0] share_target_of(input logic [WordW-1:0] d);
      logic [NumW-1:0] numer;
      logic [NumW-1:0] divisor;
      numer   = NumW'(Diff1HiWord32) << 192;
      divisor = NumW'((d == '0) ? WordW'(1) : d);
      return numer / divisor;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MaxPrinted) $display("MISMATCH: %s", msg);
    endtask

    // Note an accepted difficulty and queue its four target words, low word first.
    function void note_difficulty(input logic [WordW-1:0] d);
      logic [NumW-1:0] target;
      target_word_t    tw;
      target = share_target_of(d);
      difficulties_seen++;
      for (int k = 0; k < NWords; k++) begin
        tw.idx  = IdxW'(k);
        tw.word = target[k*WordW +: WordW];
        tw.last = (tw.idx == LastIdx);
        words_due = {words_due, tw};
      end
    endfunction

    task check_word(input logic [IdxW-1:0] idx, input logic [WordW-1:0] word,
                    input logic last);
      target_word_t due;
      words_seen++;
      if (words_due.size() == 0) begin
        report($sformatf("unexpected word idx=%0d data=%h last=%b", idx, word, last));
        return;
      end
      due = words_due.pop_front();
      if (idx !== due.idx)
        report($sformatf("word_index got %0d want %0d", idx, due.idx));
      if (word !== due.word)
        report($sformatf("target_word[%0d] got %h want %h", due.idx, word, due.word));
      if (last !== due.last)
        report($sformatf("last_word[%0d] got %b want %b", due.idx, last, due.last));
    endtask

    function int unsigned pending();
      return words_due.size();
    endfunction
  endclass

  share_target_board board;
  bit                calm;   // set: neither side idles

  // Free-running clock, 8 ns period.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Each draw is idle with a chance of roughly 37 percent, except inside the calm stretch.
  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < 37);
  endfunction

  // Draw a difficulty: full-width, small, 32-bit, near-power, shifted, zero or all-ones values.
  function automatic logic [WordW-1:0] pick_difficulty();
    logic [WordW-1:0] full;
    int unsigned      k;
    full = {$urandom, $urandom};
    k    = $urandom_range(0, WordW - 1);
    case ($urandom_range(0, 5))
      0: return full;
      1: return WordW'($urandom_range(0, 20));
      2: return WordW'($urandom);
      3: return (WordW'(1) << k) + WordW'($urandom_range(0, 2)) - WordW'(1);
      4: return full >> k;
      default: return ($urandom_range(0, 1) != 0) ? '0 : '1;
    endcase
  endfunction

  // Offer one difficulty word and hold it until the block takes it. Valid is
  // only lowered when an idle cycle is actually taken, so back-to-back words
  // never see valid dropped and raised in the same step.
  task automatic send_difficulty(input logic [WordW-1:0] d);
    while (idle_now()) begin
      din.valid <= 1'b0;
      @(posedge clk_i);
    end
    din.valid      <= 1'b1;
    din.difficulty <= d;
    do @(posedge clk_i); while (!din.ready);
    board.note_difficulty(d);
  endtask

  // Take target words whenever ready and valid meet; redraw ready every cycle.
  task automatic drain_targets();
    forever begin
      @(posedge clk_i);
      if (dout.valid && dout.ready)
        board.check_word(dout.word_index, dout.target_word, dout.last_word);
      dout.ready <= !idle_now();
    end
  endtask

  // Directed difficulties: zero, one, the extremes and the 32-bit boundary,
  // divisors that split the target's set bits, and the top bit of the divisor.
  logic [WordW-1:0] directed[] = '{
    64'h0, 64'h1, 64'h2, 64'h3, 64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF, 64'h1_0000_0000, 64'h1_0000_0001,
    64'hFFFF, 64'h1_0000, 64'hFFFF_0000, 64'h1_0001,
    64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF,
    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hFFFF_0000_0000_0000,
    64'h0000_0001_0000_FFFF, 64'h0123_4567_89AB_CDEF, 64'h7
  };

  initial begin
    board = new();
    calm  = 1'b0;
    // Known values on every input from time zero.
    rst_ni          <= 1'b0;
    din.valid       <= 1'b0;
    din.difficulty  <= '0;
    dout.ready      <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fork
      drain_targets();
    join_none

    foreach (directed[i]) send_difficulty(directed[i]);

    // Random part; items 100 to 179 run with both sides at full speed.
    for (int i = 0; i < RandomItems; i++) begin
      calm = (i >= 100) && (i < 180);
      send_difficulty(pick_difficulty());
    end
    calm = 1'b0;
    din.valid <= 1'b0;

    // Let every owed word arrive, then watch a full ring latency for strays.
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d difficulties (directed edges and random widths), %0d words checked.",
             board.difficulties_seen, board.words_seen);
    $display("Both channels idled at random, with one stretch of full-rate traffic.");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("Timed out with %0d target words outstanding.", board.pending());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
